[hw/rtl/text_console_with_mouse_cursor_defines.svh]
// Assertion macros shared by the console RTL.
`ifndef TEXT_CONSOLE_WITH_MOUSE_CURSOR_DEFINES_SVH
`define TEXT_CONSOLE_WITH_MOUSE_CURSOR_DEFINES_SVH

// Clocked check, masked while reset is high.
`define TCMC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Clocked check that also holds through reset.
`define TCMC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

[hw/rtl/tcmc_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tcmc_pkg
// Shared types and constants of the text console with mouse cursor.
// ---------------------------------------------------------------------------
package tcmc_pkg;

   localparam logic [1:0]  FUNC_PUT   = 2'd0;
   localparam logic [1:0]  FUNC_MOUSE = 2'd1;
   localparam logic [1:0]  FUNC_READ  = 2'd2;

   localparam logic [15:0] RESET_CELL = 16'h0720;
   localparam logic [7:0]  BLANK_CHAR = 8'h20;
   localparam logic [7:0]  NEWLINE    = 8'h0A;

   typedef enum logic [5:0] {
      ST_INIT     = 6'b000001,
      ST_IDLE     = 6'b000010,
      ST_EXEC     = 6'b000100,
      ST_MOUSE_RD = 6'b001000,
      ST_MOUSE_WR = 6'b010000,
      ST_SWEEP    = 6'b100000
   } state_type;

   // Exchange the foreground and background nibbles of the attribute byte.
   function automatic logic [15:0] swap_attr(logic [15:0] v);
      swap_attr = {v[11:8], v[15:12], v[7:0]};
   endfunction

endpackage

[hw/rtl/text_console_with_mouse_cursor.sv]
`timescale 1ns / 1ps
// Put char and read cell end in ST_EXEC, which sets the registered rsp strobe;
//   a mouse move that changes position also passes ST_MOUSE_RD and ST_MOUSE_WR.
// A put char that passes the last row sweeps the screen in ST_SWEEP, blanking characters.
// A new beat is taken only while busy is low, once the last one and any sweep are done.
// Reset: text cursor home, mouse at (40,12) clamped; then a fill pass in ST_INIT
//   writes every cell, busy stays high meanwhile.
// ---------------------------------------------------------------------------
// text_console_with_mouse_cursor
// Text screen RAM with a text cursor, a nibble-swapped mouse mark and readback.
// ---------------------------------------------------------------------------
`include "text_console_with_mouse_cursor_defines.svh"

module text_console_with_mouse_cursor #(
   parameter int COLUMNS = 80,
   parameter int LINES   = 25
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_func,
   input  logic [7:0]         req_char_code,
   input  logic signed [7:0]  req_delta_col,
   input  logic signed [7:0]  req_delta_row,
   input  logic [10:0]        req_cell_address,
   output logic               rsp_strobe,
   output logic [6:0]         rsp_text_column,
   output logic [4:0]         rsp_text_line,
   output logic [6:0]         rsp_pointer_column,
   output logic [4:0]         rsp_pointer_line,
   output logic               rsp_screen_cleared,
   output logic [15:0]        rsp_cell_data
);

   localparam int CELLS  = COLUMNS * LINES;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int CNT_W  = $clog2(CELLS + 1);
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int LINE_W = $clog2(LINES);
   localparam int MOUSE_COL_RST  = (40 < COLUMNS) ? 40 : COLUMNS - 1;
   localparam int MOUSE_LINE_RST = (12 < LINES) ? 12 : LINES - 1;

   function automatic logic [ADDR_W-1:0] cell_index(logic [LINE_W-1:0] ln,
                                                     logic [COL_W-1:0] cl);
      cell_index = ADDR_W'(ADDR_W'(ln) * ADDR_W'(COLUMNS) + ADDR_W'(cl));
   endfunction

   function automatic logic [COL_W-1:0] clamp_col(logic [COL_W-1:0] pos,
                                                  logic signed [7:0] d);
      logic signed [9:0] s;
      s = $signed({1'b0, 9'(pos)}) + 10'(d);
      if (s < 0)
         clamp_col = '0;
      else if (s >= $signed(10'(COLUMNS)))
         clamp_col = COL_W'(COLUMNS - 1);
      else
         clamp_col = s[COL_W-1:0];
   endfunction

   function automatic logic [LINE_W-1:0] clamp_line(logic [LINE_W-1:0] pos,
                                                    logic signed [7:0] d);
      logic signed [9:0] s;
      s = $signed({1'b0, 9'(pos)}) + 10'(d);
      if (s < 0)
         clamp_line = '0;
      else if (s >= $signed(10'(LINES)))
         clamp_line = LINE_W'(LINES - 1);
      else
         clamp_line = s[LINE_W-1:0];
   endfunction

   // Screen RAM
   logic [15:0]       mem [CELLS];
   logic [15:0]       mem_rdata_ff;
   logic [ADDR_W-1:0] mem_ra;
   logic [ADDR_W-1:0] mem_wa;
   logic [15:0]       mem_wd;
   logic              mem_we;

   always_ff @(posedge clock) begin
      if (mem_we)
         mem[mem_wa] <= mem_wd;
      mem_rdata_ff <= mem[mem_ra];
   end

   tcmc_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [COL_W-1:0]  cursor_column_ff, cursor_column_in;
   logic [LINE_W-1:0] cursor_line_ff, cursor_line_in;
   logic [COL_W-1:0]  mouse_column_ff, mouse_column_in;
   logic [LINE_W-1:0] mouse_line_ff, mouse_line_in;

   // latched beat
   logic [1:0]        func_ff;
   logic [7:0]        char_ff;
   logic signed [7:0] dcol_ff;
   logic signed [7:0] drow_ff;
   logic              addr_ok_ff;

   logic              rsp_strobe_ff, rsp_strobe_in;
   logic              cleared_ff, cleared_in;
   logic [15:0]       data_ff, data_in;
   logic [COL_W-1:0]  rsp_tcol_ff;
   logic [LINE_W-1:0] rsp_tline_ff;
   logic [COL_W-1:0]  rsp_pcol_ff;
   logic [LINE_W-1:0] rsp_pline_ff;

   logic              accept;
   logic              addr_ok;
   logic [ADDR_W-1:0] cursor_addr;
   logic [ADDR_W-1:0] mouse_addr;
   logic [COL_W-1:0]  new_mouse_col;
   logic [LINE_W-1:0] new_mouse_line;

   assign busy        = (state_ff != tcmc_pkg::ST_IDLE);
   assign accept      = start && !busy;
   assign addr_ok     = (32'(req_cell_address) < 32'(CELLS));
   assign cursor_addr = cell_index(cursor_line_ff, cursor_column_ff);
   assign mouse_addr  = cell_index(mouse_line_ff, mouse_column_ff);
   assign new_mouse_col  = clamp_col(mouse_column_ff, dcol_ff);
   assign new_mouse_line = clamp_line(mouse_line_ff, drow_ff);

   always_comb begin
      state_in         = state_ff;
      cnt_in           = cnt_ff;
      cursor_column_in = cursor_column_ff;
      cursor_line_in   = cursor_line_ff;
      mouse_column_in  = mouse_column_ff;
      mouse_line_in    = mouse_line_ff;
      rsp_strobe_in    = 1'b0;
      cleared_in       = 1'b0;
      data_in          = '0;
      mem_ra           = '0;
      mem_we           = 1'b0;
      mem_wa           = '0;
      mem_wd           = '0;
      case (state_ff)
         tcmc_pkg::ST_INIT: begin
            mem_we = 1'b1;
            mem_wa = cnt_ff[ADDR_W-1:0];
            mem_wd = (cnt_ff[ADDR_W-1:0] == mouse_addr) ?
                     tcmc_pkg::swap_attr(tcmc_pkg::RESET_CELL) : tcmc_pkg::RESET_CELL;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(CELLS - 1))
               state_in = tcmc_pkg::ST_IDLE;
         end
         tcmc_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_func)
                  tcmc_pkg::FUNC_PUT:   mem_ra = cursor_addr;
                  tcmc_pkg::FUNC_MOUSE: mem_ra = mouse_addr;
                  tcmc_pkg::FUNC_READ:  mem_ra = addr_ok ? ADDR_W'(req_cell_address) : '0;
                  default:              mem_ra = '0;
               endcase
               state_in = tcmc_pkg::ST_EXEC;
            end
         end
         tcmc_pkg::ST_EXEC: begin
            state_in = tcmc_pkg::ST_IDLE;
            case (func_ff)
               tcmc_pkg::FUNC_PUT: begin
                  if (char_ff == tcmc_pkg::NEWLINE) begin
                     cursor_column_in = '0;
                     cursor_line_in   = cursor_line_ff + 1'b1;
                  end else begin
                     mem_we = 1'b1;
                     mem_wa = cursor_addr;
                     mem_wd = {mem_rdata_ff[15:8], char_ff};
                     if (cursor_column_ff == COL_W'(COLUMNS - 1)) begin
                        cursor_column_in = '0;
                        cursor_line_in   = cursor_line_ff + 1'b1;
                     end else begin
                        cursor_column_in = cursor_column_ff + 1'b1;
                     end
                  end
                  // row advance past the last line: blank the screen
                  if (cursor_line_in != cursor_line_ff &&
                      cursor_line_ff == LINE_W'(LINES - 1)) begin
                     cursor_column_in = '0;
                     cursor_line_in   = '0;
                     cnt_in           = '0;
                     state_in         = tcmc_pkg::ST_SWEEP;
                  end else begin
                     rsp_strobe_in = 1'b1;
                  end
               end
               tcmc_pkg::FUNC_MOUSE: begin
                  // unchanged position: two swaps cancel, touch nothing
                  if (new_mouse_col != mouse_column_ff || new_mouse_line != mouse_line_ff) begin
                     mem_we          = 1'b1;
                     mem_wa          = mouse_addr;
                     mem_wd          = tcmc_pkg::swap_attr(mem_rdata_ff);
                     mouse_column_in = new_mouse_col;
                     mouse_line_in   = new_mouse_line;
                     state_in        = tcmc_pkg::ST_MOUSE_RD;
                  end else begin
                     rsp_strobe_in = 1'b1;
                  end
               end
               tcmc_pkg::FUNC_READ: begin
                  data_in       = addr_ok_ff ? mem_rdata_ff : '0;
                  rsp_strobe_in = 1'b1;
               end
               default: begin
                  rsp_strobe_in = 1'b1;
               end
            endcase
         end
         tcmc_pkg::ST_MOUSE_RD: begin
            mem_ra   = mouse_addr;
            state_in = tcmc_pkg::ST_MOUSE_WR;
         end
         tcmc_pkg::ST_MOUSE_WR: begin
            mem_we        = 1'b1;
            mem_wa        = mouse_addr;
            mem_wd        = tcmc_pkg::swap_attr(mem_rdata_ff);
            rsp_strobe_in = 1'b1;
            state_in      = tcmc_pkg::ST_IDLE;
         end
         tcmc_pkg::ST_SWEEP: begin
            // read cell n while writing back cell n-1
            if (cnt_ff != CNT_W'(CELLS))
               mem_ra = cnt_ff[ADDR_W-1:0];
            if (cnt_ff != '0) begin
               mem_we = 1'b1;
               mem_wa = ADDR_W'(cnt_ff - 1'b1);
               mem_wd = {mem_rdata_ff[15:8], tcmc_pkg::BLANK_CHAR};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(CELLS)) begin
               cleared_in    = 1'b1;
               rsp_strobe_in = 1'b1;
               state_in      = tcmc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tcmc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= tcmc_pkg::ST_INIT;
         cnt_ff           <= '0;
         cursor_column_ff <= '0;
         cursor_line_ff   <= '0;
         mouse_column_ff  <= COL_W'(MOUSE_COL_RST);
         mouse_line_ff    <= LINE_W'(MOUSE_LINE_RST);
         rsp_strobe_ff    <= 1'b0;
      end else begin
         state_ff         <= state_in;
         cnt_ff           <= cnt_in;
         cursor_column_ff <= cursor_column_in;
         cursor_line_ff   <= cursor_line_in;
         mouse_column_ff  <= mouse_column_in;
         mouse_line_ff    <= mouse_line_in;
         rsp_strobe_ff    <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff    <= req_func;
         char_ff    <= req_char_code;
         dcol_ff    <= req_delta_col;
         drow_ff    <= req_delta_row;
         addr_ok_ff <= addr_ok;
      end
      if (rsp_strobe_in) begin
         rsp_tcol_ff  <= cursor_column_in;
         rsp_tline_ff <= cursor_line_in;
         rsp_pcol_ff  <= mouse_column_in;
         rsp_pline_ff <= mouse_line_in;
         cleared_ff   <= cleared_in;
         data_ff      <= data_in;
      end
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_text_column    = 7'(rsp_tcol_ff);
   assign rsp_text_line      = 5'(rsp_tline_ff);
   assign rsp_pointer_column = 7'(rsp_pcol_ff);
   assign rsp_pointer_line   = 5'(rsp_pline_ff);
   assign rsp_screen_cleared = cleared_ff;
   assign rsp_cell_data      = data_ff;

   `TCMC_ASSERT(a_rsp_after_work, rsp_strobe |-> $past(state_ff != tcmc_pkg::ST_IDLE), "result beat without work in progress")
   `TCMC_ASSERT(a_no_rsp_after_accept, accept |=> !rsp_strobe, "result beat one cycle after accept")
   `TCMC_ASSERT(a_clear_homes, (rsp_strobe && rsp_screen_cleared) |-> (rsp_text_column == 7'd0 && rsp_text_line == 5'd0), "screen clear without cursor home")
   `TCMC_ASSERT_ALWAYS(a_cursor_range, reset || ((32'(cursor_column_ff) < 32'(COLUMNS)) && (32'(cursor_line_ff) < 32'(LINES))), "text cursor off screen")

endmodule

[dv/text_console_with_mouse_cursor_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// text_console_with_mouse_cursor_tb
// Self-checking bench for the text console: drives put-char, mouse-move, read
// and unused-function beats through start/busy, and checks every response
// strobe against a cell-accurate screen model kept inside the bench.
// ---------------------------------------------------------------------------
module text_console_with_mouse_cursor_tb;

   localparam int COLUMNS      = 80;
   localparam int LINES        = 25;
   localparam int CELLS        = COLUMNS * LINES;
   localparam int RANDOM_BEATS = 1550;
   localparam int DRAIN_LIMIT  = 3 * (CELLS + 16);
   localparam int TIMEOUT_NS   = 3_000_000;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   typedef struct {
      logic [1:0]        func;
      logic [7:0]        char_code;
      logic signed [7:0] delta_col;
      logic signed [7:0] delta_row;
      logic [10:0]       cell_address;
   } cmd_type;

   typedef struct {
      logic [6:0]  text_column;
      logic [4:0]  text_line;
      logic [6:0]  pointer_column;
      logic [4:0]  pointer_line;
      logic        screen_cleared;
      logic [15:0] cell_data;
   } report_type;

   logic clock;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0]        req_func         = '0;
   logic [7:0]        req_char_code    = '0;
   logic signed [7:0] req_delta_col    = '0;
   logic signed [7:0] req_delta_row    = '0;
   logic [10:0]       req_cell_address = '0;
   logic              rsp_strobe;
   logic [6:0]        rsp_text_column;
   logic [4:0]        rsp_text_line;
   logic [6:0]        rsp_pointer_column;
   logic [4:0]        rsp_pointer_line;
   logic              rsp_screen_cleared;
   logic [15:0]       rsp_cell_data;

   // screen model
   logic [15:0] screen_model [CELLS];
   int cur_col, cur_line, ptr_col, ptr_line;

   report_type predicted_reports[$];
   int mismatches = 0;
   int beats_sent = 0;
   bit no_idle    = 1'b0;

   text_console_with_mouse_cursor #(
      .COLUMNS(COLUMNS),
      .LINES  (LINES)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_func          (req_func),
      .req_char_code     (req_char_code),
      .req_delta_col     (req_delta_col),
      .req_delta_row     (req_delta_row),
      .req_cell_address  (req_cell_address),
      .rsp_strobe        (rsp_strobe),
      .rsp_text_column   (rsp_text_column),
      .rsp_text_line     (rsp_text_line),
      .rsp_pointer_column(rsp_pointer_column),
      .rsp_pointer_line  (rsp_pointer_line),
      .rsp_screen_cleared(rsp_screen_cleared),
      .rsp_cell_data     (rsp_cell_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("TEST FAILED");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Screen model
   // -------------------------------------------------------------------------
   function automatic void exchange_attr(int col, int row);
      int a;
      logic [15:0] v;
      a = row * COLUMNS + col;
      if (a < CELLS) begin
         v = screen_model[a];
         screen_model[a] = ((v & 16'h0F00) << 4) | ((v & 16'hF000) >> 4) | (v & 16'h00FF);
      end
   endfunction

   function automatic int clamp_offset(int pos, logic signed [7:0] d, int lim);
      int s;
      s = pos + int'(d);
      if (s >= lim) s = lim - 1;
      if (s < 0) s = 0;
      return s;
   endfunction

   function automatic void console_reset();
      for (int i = 0; i < CELLS; i++) screen_model[i] = tcmc_pkg::RESET_CELL;
      cur_col  = 0;
      cur_line = 0;
      ptr_col  = (40 < COLUMNS) ? 40 : COLUMNS - 1;
      ptr_line = (12 < LINES) ? 12 : LINES - 1;
      exchange_attr(ptr_col, ptr_line);
   endfunction

   function automatic report_type console_step(cmd_type c);
      report_type r;
      int a;
      r = '{default: '0};
      case (c.func)
         tcmc_pkg::FUNC_PUT: begin
            if (c.char_code == tcmc_pkg::NEWLINE) begin
               cur_col = 0;
               cur_line++;
            end else begin
               a = cur_line * COLUMNS + cur_col;
               if (a < CELLS) screen_model[a] = {screen_model[a][15:8], c.char_code};
               cur_col++;
            end
            if (cur_col >= COLUMNS) begin
               cur_col = 0;
               cur_line++;
            end
            // past the last row: blank characters, keep attributes, home cursor
            if (cur_line >= LINES) begin
               for (int i = 0; i < CELLS; i++)
                  screen_model[i] = {screen_model[i][15:8], tcmc_pkg::BLANK_CHAR};
               cur_col  = 0;
               cur_line = 0;
               r.screen_cleared = 1'b1;
            end
         end
         tcmc_pkg::FUNC_MOUSE: begin
            exchange_attr(ptr_col, ptr_line);
            ptr_col  = clamp_offset(ptr_col, c.delta_col, COLUMNS);
            ptr_line = clamp_offset(ptr_line, c.delta_row, LINES);
            exchange_attr(ptr_col, ptr_line);
         end
         tcmc_pkg::FUNC_READ: begin
            if (c.cell_address < CELLS) r.cell_data = screen_model[c.cell_address];
         end
         default: ;
      endcase
      r.text_column    = 7'(cur_col);
      r.text_line      = 5'(cur_line);
      r.pointer_column = 7'(ptr_col);
      r.pointer_line   = 5'(ptr_line);
      return r;
   endfunction

   // -------------------------------------------------------------------------
   // Driver
   // -------------------------------------------------------------------------
   function automatic cmd_type random_cmd(logic [1:0] f);
      cmd_type c;
      c.func         = f;
      c.char_code    = 8'($urandom_range(0, 255));
      c.delta_col    = 8'($urandom_range(0, 255));
      c.delta_row    = 8'($urandom_range(0, 255));
      c.cell_address = 11'($urandom_range(0, 2047));
      return c;
   endfunction

   // Called just after a rising edge; returns at the edge that took the beat.
   task automatic send_beat(cmd_type c);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_func         <= c.func;
      req_char_code    <= c.char_code;
      req_delta_col    <= c.delta_col;
      req_delta_row    <= c.delta_row;
      req_cell_address <= c.cell_address;
      start            <= 1'b1;
      do @(posedge clock); while (busy);
      predicted_reports.push_back(console_step(c));
      if (c.func != FUNC_UNUSED) beats_sent++;
   endtask

   task automatic put_char(logic [7:0] ch);
      cmd_type c;
      c = random_cmd(tcmc_pkg::FUNC_PUT);
      c.char_code = ch;
      send_beat(c);
   endtask

   task automatic move_mouse(logic signed [7:0] dc, logic signed [7:0] dr);
      cmd_type c;
      c = random_cmd(tcmc_pkg::FUNC_MOUSE);
      c.delta_col = dc;
      c.delta_row = dr;
      send_beat(c);
   endtask

   task automatic read_cell(int addr);
      cmd_type c;
      c = random_cmd(tcmc_pkg::FUNC_READ);
      c.cell_address = 11'(addr);
      send_beat(c);
   endtask

   // -------------------------------------------------------------------------
   // Response check
   // -------------------------------------------------------------------------
   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch on %s: expected 0x%0h, got 0x%0h", name, want, got);
      end
   endtask

   always @(posedge clock) begin : check_results
      report_type want;
      if (!reset && rsp_strobe) begin
         if (predicted_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("response strobe with nothing outstanding");
         end else begin
            want = predicted_reports.pop_front();
            check_field("text_column", want.text_column, rsp_text_column);
            check_field("text_line", want.text_line, rsp_text_line);
            check_field("pointer_column", want.pointer_column, rsp_pointer_column);
            check_field("pointer_line", want.pointer_line, rsp_pointer_line);
            check_field("screen_cleared", want.screen_cleared, rsp_screen_cleared);
            check_field("cell_data", want.cell_data, rsp_cell_data);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------
   task automatic test_reset_contents();
      cmd_type c;
      read_cell(0);
      read_cell(12 * COLUMNS + 40);
      read_cell(CELLS - 1);
      read_cell(CELLS);          // out of range reads zero
      read_cell(2047);
      c = random_cmd(FUNC_UNUSED);
      send_beat(c);
   endtask

   task automatic test_put_char();
      put_char(8'h41);
      put_char(8'h00);
      put_char(8'hFF);
      put_char(tcmc_pkg::NEWLINE);
      read_cell(0);
      read_cell(2);
      read_cell(COLUMNS);
   endtask

   task automatic test_mouse_move();
      move_mouse(8'sd127, 8'sd127);      // clamp at bottom right
      move_mouse(-8'sd128, -8'sd128);    // clamp at top left
      move_mouse(8'sd0, 8'sd0);          // same cell, swapped twice
      move_mouse(8'sd5, -8'sd1);
      read_cell(ptr_line * COLUMNS + ptr_col);
      read_cell(0);
   endtask

   task automatic text_burst();
      int len, nl_pct;
      logic [7:0] ch;
      len = $urandom_range(10, 120);
      case ($urandom_range(0, 2))
         0: nl_pct = 0;
         1: nl_pct = 4;
         default: nl_pct = 30;
      endcase
      repeat (len) begin
         if ($urandom_range(0, 99) < nl_pct) ch = tcmc_pkg::NEWLINE;
         else ch = 8'($urandom_range(0, 255));
         put_char(ch);
      end
   endtask

   // newlines down to the last row, then characters until the row end wraps
   task automatic run_to_bottom();
      logic [7:0] ch;
      while (cur_line < LINES - 1) put_char(tcmc_pkg::NEWLINE);
      do begin
         do ch = 8'($urandom_range(0, 255)); while (ch == tcmc_pkg::NEWLINE);
         put_char(ch);
      end while (cur_line != 0 || cur_col != 0);
   endtask

   task automatic mouse_burst();
      int mode;
      logic signed [7:0] dc, dr;
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(1, 8)) begin
         case (mode)
            0: begin
               dc = 8'($urandom_range(0, 255));
               dr = 8'($urandom_range(0, 255));
            end
            1: begin
               dc = 8'($urandom_range(0, 6) - 3);
               dr = 8'($urandom_range(0, 6) - 3);
            end
            default: begin
               dc = ($urandom_range(0, 1) != 0) ? 8'sd127 : -8'sd128;
               dr = ($urandom_range(0, 2) == 0) ? 8'sd0 :
                    (($urandom_range(0, 1) != 0) ? 8'sd127 : -8'sd128);
            end
         endcase
         move_mouse(dc, dr);
      end
   endtask

   task automatic read_burst();
      int a;
      repeat ($urandom_range(1, 12)) begin
         case ($urandom_range(0, 3))
            0: begin
               a = cur_line * COLUMNS + cur_col - $urandom_range(0, 4);
               if (a < 0) a = 0;
            end
            1: begin
               a = ptr_line * COLUMNS + ptr_col + $urandom_range(0, 2) - 1;
               if (a < 0) a = 0;
            end
            2: a = $urandom_range(0, CELLS - 1);
            default: a = $urandom_range(0, 2047);
         endcase
         read_cell(a);
      end
   endtask

   task automatic test_random_traffic();
      int target;
      target = beats_sent + RANDOM_BEATS;
      while (beats_sent < target) begin
         no_idle = ($urandom_range(0, 2) == 0);
         case ($urandom_range(0, 11))
            0, 1, 2: text_burst();
            3:       run_to_bottom();
            4, 5, 6: mouse_burst();
            7, 8, 9, 10: read_burst();
            default: repeat ($urandom_range(1, 3)) send_beat(random_cmd(FUNC_UNUSED));
         endcase
      end
      no_idle = 1'b0;
   endtask

   initial begin
      int drain;
      console_reset();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_reset_contents();
      test_put_char();
      test_mouse_move();
      test_random_traffic();

      start <= 1'b0;
      drain = 0;
      while (predicted_reports.size() > 0 && drain < DRAIN_LIMIT) begin
         @(posedge clock);
         drain++;
      end
      repeat (16) @(posedge clock);
      if (predicted_reports.size() > 0) begin
         mismatches += predicted_reports.size();
         $display("%0d responses never arrived", predicted_reports.size());
      end

      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
